@@ sv/integer_to_decimal_ascii_top_defines.svh @@
// Assertion macros shared by the integer to decimal ASCII RTL.
`ifndef INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INTEGER_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define I2DA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2da assertion failed");
`define I2DA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2da assertion failed");
`else
`define I2DA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define I2DA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/i2da_pkg.sv @@
// Types and constants of the integer to decimal ASCII converter.
`default_nettype none

package i2da_pkg;

    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int STEP_BITS  = 4;
    localparam int MAG_W      = 64;
    localparam int HALF_W     = 32;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0] STEPS_32_M1 = CNT_W'(HALF_W / STEP_BITS - 1);
    localparam logic [CNT_W-1:0] STEPS_64_M1 = CNT_W'(MAG_W / STEP_BITS - 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        OP_S32 = 2'd0,
        OP_U32 = 2'd1,
        OP_S64 = 2'd2,
        OP_U64 = 2'd3
    } op_t;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        digit_t [NUM_DIGITS-1:0] digits;
        logic   [NUM_DIGITS-1:0] mask;
        logic                    neg;
    } conv_result_t;

endpackage

`default_nettype wire

@@ sv/i2da_cell.sv @@
// One BCD digit cell of the shift-and-add-3 row, four bits per cycle while step is high.
`default_nettype none

module i2da_cell (
    input  wire logic                       aclk,
    input  wire logic                       clear,
    input  wire logic                       step,
    input  wire logic [i2da_pkg::STEP_BITS-1:0] in_bits,
    output logic      [i2da_pkg::STEP_BITS-1:0] out_bits,
    input  wire logic                       above_in,
    output logic                            above_out,
    output i2da_pkg::digit_t                digit
);
    import i2da_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t work;
    digit_t corr;

    // Each sub-step corrects the digit, then shifts in one bit from below
    // and passes its top bit to the cell above.
    always_comb begin
        work     = digit_reg;
        corr     = digit_reg;
        out_bits = '0;
        for (int k = STEP_BITS - 1; k >= 0; k--) begin
            corr        = (work >= 4'd5) ? work + 4'd3 : work;
            out_bits[k] = corr[DIGIT_W-1];
            work        = {corr[DIGIT_W-2:0], in_bits[k]};
        end
        if (clear) begin
            digit_next = '0;
        end else if (step) begin
            digit_next = work;
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit     = digit_reg;
    assign above_out = above_in | (digit_reg != '0);

endmodule

`default_nettype wire

@@ sv/i2da_conv.sv @@
// Sign split and binary to BCD conversion over a row of digit cells.
`default_nettype none
`include "integer_to_decimal_ascii_top_defines.svh"

module i2da_conv (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [i2da_pkg::MAG_W-1:0]  s_value_bits,
    input  wire logic [1:0]                  s_op,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output i2da_pkg::conv_result_t           res
);
    import i2da_pkg::*;

    logic             run_reg, run_next;
    logic             hold_reg, hold_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;

    logic             accept;
    logic             handoff;
    logic             last_step;
    logic             in_neg;
    logic [MAG_W-1:0] in_mag;
    logic [CNT_W-1:0] in_steps;
    logic [HALF_W-1:0] low_w;

    logic [STEP_BITS-1:0] carry [NUM_DIGITS];
    logic [NUM_DIGITS:0]  above_w;
    digit_t [NUM_DIGITS-1:0] digits_w;

    assign accept    = s_valid & s_ready;
    assign handoff   = hold_reg & res_ready;
    assign last_step = run_reg & (cnt_reg == '0);
    assign s_ready   = ~run_reg & (~hold_reg | res_ready);
    assign low_w     = s_value_bits[HALF_W-1:0];

    // The 32-bit formats are placed in the upper half so the row always
    // takes bits from the top of the shift register.
    always_comb begin
        in_neg   = 1'b0;
        in_mag   = s_value_bits;
        in_steps = STEPS_64_M1;
        unique case (op_t'(s_op))
            OP_S32: begin
                in_neg   = low_w[HALF_W-1];
                in_mag   = {(in_neg ? (~low_w + 1'b1) : low_w), {HALF_W{1'b0}}};
                in_steps = STEPS_32_M1;
            end
            OP_U32: begin
                in_mag   = {low_w, {HALF_W{1'b0}}};
                in_steps = STEPS_32_M1;
            end
            OP_S64: begin
                in_neg   = s_value_bits[MAG_W-1];
                in_mag   = in_neg ? (~s_value_bits + 1'b1) : s_value_bits;
            end
            OP_U64: begin
                in_mag   = s_value_bits;
            end
            default: begin
                in_mag   = s_value_bits;
            end
        endcase
    end

    always_comb begin
        run_next  = run_reg;
        hold_next = hold_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        if (handoff) begin
            hold_next = 1'b0;
        end
        if (accept) begin
            run_next = 1'b1;
            cnt_next = in_steps;
            mag_next = in_mag;
            neg_next = in_neg;
        end else if (run_reg) begin
            cnt_next = cnt_reg - 1'b1;
            mag_next = mag_reg << STEP_BITS;
            if (last_step) begin
                run_next  = 1'b0;
                hold_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            hold_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    assign above_w[NUM_DIGITS] = 1'b0;

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        logic [STEP_BITS-1:0] cell_in;
        if (i == 0) begin : g_first
            assign cell_in = mag_reg[MAG_W-1 -: STEP_BITS];
        end else begin : g_rest
            assign cell_in = carry[i-1];
        end
        i2da_cell u_cell (
            .aclk      (aclk),
            .clear     (accept),
            .step      (run_reg),
            .in_bits   (cell_in),
            .out_bits  (carry[i]),
            .above_in  (above_w[i+1]),
            .above_out (above_w[i]),
            .digit     (digits_w[i])
        );
    end

    assign res_valid  = hold_reg;
    assign res.digits = digits_w;
    assign res.mask   = above_w[NUM_DIGITS-1:0];
    assign res.neg    = neg_reg;

    // The top digit never overflows: 64 bits fit in twenty decimal digits.
    `I2DA_ASSERT_IMP(a_no_overflow, aclk, aresetn, run_reg, carry[NUM_DIGITS-1] == '0)
    `I2DA_ASSERT_NXT(a_done_holds, aclk, aresetn, last_step, hold_reg && !run_reg)

endmodule

`default_nettype wire

@@ sv/i2da_emit.sv @@
// Character emitter: sign, then the significant digits, most significant first.
`default_nettype none
`include "integer_to_decimal_ascii_top_defines.svh"

module i2da_emit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  res_valid,
    output logic                       res_ready,
    input  wire i2da_pkg::conv_result_t res,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [7:0]                 m_out_char,
    output logic                       m_last
);
    import i2da_pkg::*;

    logic                    full_reg, full_next;
    logic                    sign_reg, sign_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    digit_t [NUM_DIGITS-1:0] dig_reg, dig_next;

    logic             take;
    logic             load;
    logic             load_single;
    logic [IDX_W-1:0] ndig;
    digit_t           cur_digit;

    assign take      = m_valid & m_ready;
    assign res_ready = ~full_reg | (take & m_last);
    assign load      = res_valid & res_ready;

    // The lowest digit always prints, so zero gives a single character.
    assign ndig = IDX_W'($countones({res.mask[NUM_DIGITS-1:1], 1'b1}));

    // A positive single-digit number is one character long.
    assign load_single = ~res.neg & (ndig == IDX_W'(1));

    always_comb begin
        full_next = full_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        dig_next  = dig_reg;
        if (take) begin
            if (sign_reg) begin
                sign_next = 1'b0;
            end else if (idx_reg == '0) begin
                full_next = 1'b0;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
        if (load) begin
            full_next = 1'b1;
            sign_next = res.neg;
            idx_next  = ndig - 1'b1;
            dig_next  = res.digits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        sign_reg <= sign_next;
        idx_reg  <= idx_next;
        dig_reg  <= dig_next;
    end

    assign cur_digit  = dig_reg[idx_reg];
    assign m_valid    = full_reg;
    assign m_out_char = sign_reg ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, cur_digit});
    assign m_last     = ~sign_reg & (idx_reg == '0);

    `I2DA_ASSERT_IMP(a_idx_range, aclk, aresetn, full_reg, idx_reg < IDX_W'(NUM_DIGITS))
    `I2DA_ASSERT_NXT(a_load_shows, aclk, aresetn, load, m_valid && (m_last == $past(load_single)))

endmodule

`default_nettype wire

@@ sv/integer_to_decimal_ascii_top.sv @@
// Top level of the integer to decimal ASCII converter.
//
// Input channel s_*: one word holds a 64-bit value and a 2-bit format
// (signed 32, unsigned 32, signed 64, unsigned 64); in the 32-bit formats
// the upper half of the value is ignored. Output channel m_*: one word per
// character, '-' for a negative value and then the digits, most significant
// first, with m_last on the final character. Leading zeros are dropped.
// A row of twenty BCD cells takes four magnitude bits per cycle, 32 bits in
// all for the 32-bit formats and 64 for the 64-bit formats.
// The first character appears once the conversion is done and its digits
// have moved into the emitter, which sends one character per cycle while
// m_ready is high, so the next word is converted while the previous text
// goes out. When m_ready is low the current character holds and the
// converter stops taking words once its finished result waits.
// Reset (aresetn low, synchronous) drops any word in flight.
`default_nettype none

module integer_to_decimal_ascii_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [i2da_pkg::MAG_W-1:0] s_value_bits,
    input  wire logic [1:0]                 s_op,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [7:0]                      m_out_char,
    output logic                            m_last
);
    import i2da_pkg::*;

    logic         res_valid;
    logic         res_ready;
    conv_result_t res;

    i2da_conv u_conv (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value_bits (s_value_bits),
        .s_op         (s_op),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    i2da_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

@@ tb/sv/i2da_text_checker.sv @@
// Watches both channels of the decimal ASCII converter, predicts its text and compares it.
module i2da_text_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire logic [i2da_pkg::MAG_W-1:0] s_value_bits,
    input  wire logic [1:0]                 s_op,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire logic [7:0]                 m_out_char,
    input  wire logic                       m_last,
    output int                              error_count,
    output int                              chars_pending,
    output int                              words_taken,
    output int                              chars_checked
);
    import i2da_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];

    initial begin
        error_count   = 0;
        chars_pending = 0;
        words_taken   = 0;
        chars_checked = 0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40) begin
            $display("MISMATCH: %s (char %0d)", what, chars_checked);
        end
    endtask

    // Appends the decimal text of one input word to the expected characters.
    function automatic void queue_decimal_text(input logic [MAG_W-1:0] raw, input op_t fmt);
        logic [MAG_W-1:0]  mag;
        logic [HALF_W-1:0] low;
        logic              neg;
        logic [7:0]        digits[NUM_DIGITS];
        int                n;
        text_char_t        c;

        low = raw[HALF_W-1:0];
        neg = 1'b0;
        case (fmt)
            OP_S32: begin
                neg = low[HALF_W-1];
                if (neg) begin
                    low = ~low + 1'b1;
                end
                mag = {{(MAG_W-HALF_W){1'b0}}, low};
            end
            OP_U32: mag = {{(MAG_W-HALF_W){1'b0}}, low};
            OP_S64: begin
                neg = raw[MAG_W-1];
                mag = neg ? ~raw + 1'b1 : raw;
            end
            default: mag = raw;
        endcase

        n = 0;
        do begin
            digits[n] = CHAR_ZERO + 8'(mag % 64'd10);
            n++;
            mag = mag / 64'd10;
        end while (mag != 0 && n < NUM_DIGITS);

        if (neg) begin
            c.ch   = CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.ch   = digits[k];
            c.last = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                              m_out_char, m_last));
                end else begin
                    want = expected_text.pop_front();
                    if (m_out_char !== want.ch) begin
                        report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                                  m_out_char, want.ch));
                    end
                    if (m_last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b", m_last, want.last));
                    end
                end
                chars_checked++;
            end
            if (s_valid && s_ready) begin
                queue_decimal_text(s_value_bits, op_t'(s_op));
                words_taken++;
            end
            chars_pending = expected_text.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Stimulus, handshake pacing and verdict for the integer to decimal ASCII converter.
module tb_top;
    import i2da_pkg::*;

    localparam int RANDOM_WORDS = 320;
    localparam int CYCLE_LIMIT  = 400000;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [MAG_W-1:0] s_value_bits;
    logic [1:0]       s_op;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_out_char;
    logic             m_last;

    int error_count;
    int chars_pending;
    int words_taken;
    int chars_checked;
    int cycle_count;

    // When set, both sides run back to back with no idle cycles.
    logic steady;

    integer_to_decimal_ascii_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value_bits (s_value_bits),
        .s_op         (s_op),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last       (m_last)
    );

    i2da_text_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value_bits  (s_value_bits),
        .s_op          (s_op),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last        (m_last),
        .error_count   (error_count),
        .chars_pending (chars_pending),
        .words_taken   (words_taken),
        .chars_checked (chars_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d chars outstanding",
                 cycle_count, chars_pending);
        $display("DONE: errors detected");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [MAG_W-1:0] value, input op_t fmt);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_value_bits <= value;
        s_op         <= fmt;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [MAG_W-1:0] random_value();
        logic [MAG_W-1:0] v;
        logic [MAG_W-1:0] p;
        int               w;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: begin
                w = $urandom_range(1, 64);
                v = v & ((64'd1 << w) - 64'd1);
            end
            1: begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                v = p - 64'd1 + 64'($urandom_range(0, 2));
            end
            2: v = ~64'($urandom_range(0, 100000)) + 64'd1;
            3: v = {v[63:32], 32'h8000_0000 - 32'd3 + 32'($urandom_range(0, 6))};
            4: v = {1'b1, v[62:0]};
            default: ;
        endcase
        return v;
    endfunction

    // Result side: a random stall before each character, unless running steady.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_value_bits = '0;
        s_op         = OP_S32;
        steady       = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero, the extremes of every format, digit boundaries and ignored high halves.
        send_word(64'd0, OP_S32);
        send_word(64'd0, OP_U32);
        send_word(64'd0, OP_S64);
        send_word(64'd0, OP_U64);
        send_word(64'h0000_0000_8000_0000, OP_S32);
        send_word(64'hFFFF_FFFF_7FFF_FFFF, OP_S32);
        send_word(64'h0000_0000_FFFF_FFFF, OP_S32);
        send_word(64'hA5A5_A5A5_0000_0000, OP_S32);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, OP_U32);
        send_word(64'h5A5A_5A5A_0000_0000, OP_U32);
        send_word(64'h8000_0000_0000_0000, OP_S64);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, OP_S64);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, OP_S64);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, OP_U64);
        send_word(64'h8000_0000_0000_0000, OP_U64);
        send_word(64'd1, OP_U64);
        send_word(64'd9, OP_U64);
        send_word(64'd10, OP_S64);
        send_word(64'd9_999_999_999_999_999_999, OP_U64);
        send_word(64'd10_000_000_000_000_000_000, OP_U64);
        send_word(64'd999_999_999, OP_S32);
        send_word(64'd1_000_000_000, OP_U32);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 40 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            send_word(random_value(), op_t'($urandom_range(0, 3)));
        end
        s_valid <= 1'b0;
        steady  = 1'b0;

        while (chars_pending != 0) @(posedge aclk);
        // Nothing further should appear once the converter has drained.
        repeat (40) @(posedge aclk);

        $display("Sent %0d numbers in all four formats, checked %0d characters.",
                 words_taken, chars_checked);
        $display("Both channels were paced by random idle cycles with stall-free stretches.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/i2da_pkg.sv
sv/i2da_cell.sv
sv/i2da_conv.sv
sv/i2da_emit.sv
sv/integer_to_decimal_ascii_top.sv
tb/sv/i2da_text_checker.sv
tb/sv/tb_top.sv
